### design/scsp_pkg.sv
package scsp_pkg;

	// characters the parser reacts to
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UB    = 8'h42;
	localparam logic [7:0] CH_UC    = 8'h43;
	localparam logic [7:0] CH_UD    = 8'h44;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_UG    = 8'h47;
	localparam logic [7:0] CH_UI    = 8'h49;
	localparam logic [7:0] CH_UK    = 8'h4B;
	localparam logic [7:0] CH_UL    = 8'h4C;
	localparam logic [7:0] CH_UM    = 8'h4D;
	localparam logic [7:0] CH_UN    = 8'h4E;
	localparam logic [7:0] CH_UO    = 8'h4F;
	localparam logic [7:0] CH_UQ    = 8'h51;
	localparam logic [7:0] CH_UR    = 8'h52;
	localparam logic [7:0] CH_US    = 8'h53;
	localparam logic [7:0] CH_UT    = 8'h54;
	localparam logic [7:0] CH_UV    = 8'h56;
	localparam logic [7:0] CH_UW    = 8'h57;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_UY    = 8'h59;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LB    = 8'h62;
	localparam logic [7:0] CH_LD    = 8'h64;
	localparam logic [7:0] CH_LS    = 8'h73;

	// star types
	localparam logic [1:0] STAR_NORMAL      = 2'd0;
	localparam logic [1:0] STAR_WHITE_DWARF = 2'd1;
	localparam logic [1:0] STAR_NEUTRON     = 2'd2;
	localparam logic [1:0] STAR_BLACK_HOLE  = 2'd3;

	// spectral classes
	localparam logic [4:0] SPEC_UNKNOWN = 5'd0;
	localparam logic [4:0] SPEC_O       = 5'd1;
	localparam logic [4:0] SPEC_B       = 5'd2;
	localparam logic [4:0] SPEC_A       = 5'd3;
	localparam logic [4:0] SPEC_F       = 5'd4;
	localparam logic [4:0] SPEC_G       = 5'd5;
	localparam logic [4:0] SPEC_K       = 5'd6;
	localparam logic [4:0] SPEC_M       = 5'd7;
	localparam logic [4:0] SPEC_R       = 5'd8;
	localparam logic [4:0] SPEC_N       = 5'd9;
	localparam logic [4:0] SPEC_C       = 5'd10;
	localparam logic [4:0] SPEC_S       = 5'd11;
	localparam logic [4:0] SPEC_L       = 5'd12;
	localparam logic [4:0] SPEC_T       = 5'd13;
	localparam logic [4:0] SPEC_Y       = 5'd14;
	localparam logic [4:0] SPEC_WC      = 5'd15;
	localparam logic [4:0] SPEC_WN      = 5'd16;
	localparam logic [4:0] SPEC_WO      = 5'd17;
	localparam logic [4:0] SPEC_D       = 5'd18;
	localparam logic [4:0] SPEC_DA      = 5'd19;
	localparam logic [4:0] SPEC_DB      = 5'd20;
	localparam logic [4:0] SPEC_DC      = 5'd21;
	localparam logic [4:0] SPEC_DO      = 5'd22;
	localparam logic [4:0] SPEC_DQ      = 5'd23;
	localparam logic [4:0] SPEC_DX      = 5'd24;
	localparam logic [4:0] SPEC_DZ      = 5'd25;

	// luminosity classes
	localparam logic [3:0] LUM_UNKNOWN = 4'd0;
	localparam logic [3:0] LUM_0       = 4'd1;
	localparam logic [3:0] LUM_IA_PLUS = 4'd2;
	localparam logic [3:0] LUM_IA      = 4'd3;
	localparam logic [3:0] LUM_IAB     = 4'd4;
	localparam logic [3:0] LUM_IB      = 4'd5;
	localparam logic [3:0] LUM_I       = 4'd6;
	localparam logic [3:0] LUM_II      = 4'd7;
	localparam logic [3:0] LUM_III     = 4'd8;
	localparam logic [3:0] LUM_IV      = 4'd9;
	localparam logic [3:0] LUM_V       = 4'd10;
	localparam logic [3:0] LUM_VI      = 4'd11;

	localparam logic [6:0] TENS_SCALE = 7'd10;

	// transitions a single character can walk before it is consumed
	localparam int unsigned MAX_HOPS = 4;

	typedef enum logic [14:0] {
		ST_BEGIN     = 15'b000000000000001,
		ST_END       = 15'b000000000000010,
		ST_WOLF      = 15'b000000000000100,
		ST_WD        = 15'b000000000001000,
		ST_WD_EX     = 15'b000000000010000,
		ST_SD        = 15'b000000000100000,
		ST_SPEC      = 15'b000000001000000,
		ST_SUB       = 15'b000000010000000,
		ST_SUB_DOT   = 15'b000000100000000,
		ST_SUB_TENTH = 15'b000001000000000,
		ST_LUM       = 15'b000010000000000,
		ST_LUM_I     = 15'b000100000000000,
		ST_LUM_IA    = 15'b001000000000000,
		ST_LUM_II    = 15'b010000000000000,
		ST_LUM_V     = 15'b100000000000000
	} pstate_t;

	// one classified character as it travels through the queue
	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic [4:0] main_cls;
		logic [4:0] wd_cls;
		logic       is_dig;
		logic [3:0] dig;
	} entry_t;

	// parser state and accumulated result
	typedef struct packed {
		pstate_t    state;
		logic [7:0] prev_char;
		logic [1:0] star_type;
		logic [4:0] spectral;
		logic [6:0] subclass;
		logic [3:0] lum;
		logic       err;
	} ctx_t;

	typedef struct packed {
		ctx_t ctx;
		logic used;
	} adv_t;

	localparam ctx_t CTX_RESET = '{
		state:     ST_BEGIN,
		prev_char: CH_NUL,
		star_type: STAR_NORMAL,
		spectral:  SPEC_UNKNOWN,
		subclass:  7'd0,
		lum:       LUM_UNKNOWN,
		err:       1'b0
	};

	// one transition of the character state machine
	function automatic adv_t parse_advance(input ctx_t c, input entry_t e);
		adv_t r;
		r.ctx  = c;
		r.used = 1'b0;
		case (c.state)
			ST_BEGIN: begin
				if (e.ch == CH_UX) begin
					r.ctx.star_type = STAR_BLACK_HOLE;
					r.ctx.state     = ST_END;
				end else if (e.ch == CH_UQ) begin
					r.ctx.star_type = STAR_NEUTRON;
					r.ctx.state     = ST_END;
				end else if (e.ch == CH_UD) begin
					r.ctx.star_type = STAR_WHITE_DWARF;
					r.ctx.spectral  = SPEC_D;
					r.ctx.state     = ST_WD;
					r.used          = 1'b1;
				end else if (e.ch == CH_LS) begin
					r.ctx.star_type = STAR_NORMAL;
					r.ctx.state     = ST_SD;
					r.used          = 1'b1;
				end else if (e.ch == CH_QMARK) begin
					r.ctx.state = ST_END;
				end else begin
					r.ctx.state = ST_SPEC;
				end
			end
			ST_SPEC: begin
				if (e.ch == CH_UW) begin
					r.ctx.state = ST_WOLF;
					r.used      = 1'b1;
				end else if (e.main_cls != SPEC_UNKNOWN) begin
					r.ctx.spectral = e.main_cls;
					r.ctx.state    = ST_SUB;
					r.used         = 1'b1;
				end else begin
					r.ctx.state = ST_END;
				end
			end
			ST_WOLF: begin
				if (e.ch == CH_UC) begin
					r.ctx.spectral = SPEC_WC;
					r.ctx.state    = ST_SUB;
					r.used         = 1'b1;
				end else if (e.ch == CH_UN) begin
					r.ctx.spectral = SPEC_WN;
					r.ctx.state    = ST_SUB;
					r.used         = 1'b1;
				end else if (e.ch == CH_UO) begin
					r.ctx.spectral = SPEC_WO;
					r.ctx.state    = ST_SUB;
					r.used         = 1'b1;
				end else begin
					r.ctx.state = ST_END;
				end
			end
			ST_WD: begin
				if (e.wd_cls != SPEC_UNKNOWN) begin
					r.ctx.spectral = e.wd_cls;
					r.ctx.state    = ST_WD_EX;
					r.used         = 1'b1;
				end else begin
					r.ctx.spectral = SPEC_D;
					r.ctx.state    = ST_SUB;
				end
			end
			ST_WD_EX: begin
				r.ctx.state = ST_SUB;
				if (e.wd_cls != SPEC_UNKNOWN) begin
					r.used = 1'b1;
					if (e.ch == c.prev_char) begin
						r.ctx.err = 1'b1;
					end
				end
			end
			ST_SD: begin
				if (e.ch == CH_LD) begin
					r.ctx.lum   = LUM_VI;
					r.ctx.state = ST_SPEC;
					r.used      = 1'b1;
				end else begin
					r.ctx.state = ST_END;
				end
			end
			ST_SUB: begin
				if (e.is_dig) begin
					r.ctx.subclass = 7'(7'(e.dig) * TENS_SCALE);
					r.ctx.state    = ST_SUB_DOT;
					r.used         = 1'b1;
				end else begin
					r.ctx.state = ST_LUM;
				end
			end
			ST_SUB_DOT: begin
				if (e.ch == CH_DOT) begin
					r.ctx.state = ST_SUB_TENTH;
					r.used      = 1'b1;
				end else begin
					r.ctx.state = ST_LUM;
				end
			end
			ST_SUB_TENTH: begin
				if (e.is_dig) begin
					r.ctx.subclass = c.subclass + 7'(e.dig);
				end
				r.ctx.state = ST_LUM;
				r.used      = 1'b1;
			end
			ST_LUM: begin
				if (e.ch == CH_ZERO) begin
					r.ctx.lum   = LUM_0;
					r.ctx.state = ST_END;
				end else if (e.ch == CH_UI) begin
					r.ctx.state = ST_LUM_I;
					r.used      = 1'b1;
				end else if (e.ch == CH_UV) begin
					r.ctx.state = ST_LUM_V;
					r.used      = 1'b1;
				end else if (e.ch == CH_SPACE) begin
					r.used = 1'b1;
				end else begin
					r.ctx.state = ST_END;
				end
			end
			ST_LUM_I: begin
				if (e.ch == CH_LA) begin
					r.ctx.state = ST_LUM_IA;
					r.used      = 1'b1;
				end else if (e.ch == CH_LB) begin
					r.ctx.lum   = LUM_IB;
					r.ctx.state = ST_END;
					r.used      = 1'b1;
				end else if (e.ch == CH_UI) begin
					r.ctx.state = ST_LUM_II;
					r.used      = 1'b1;
				end else if (e.ch == CH_UV) begin
					r.ctx.lum   = LUM_IV;
					r.ctx.state = ST_END;
					r.used      = 1'b1;
				end else begin
					r.ctx.lum   = LUM_I;
					r.ctx.state = ST_END;
				end
			end
			ST_LUM_IA: begin
				if (e.ch == CH_PLUS) begin
					r.ctx.lum = LUM_IA_PLUS;
				end else if (e.ch == CH_LB) begin
					r.ctx.lum = LUM_IAB;
				end else begin
					r.ctx.lum = LUM_IA;
				end
				r.ctx.state = ST_END;
			end
			ST_LUM_II: begin
				r.ctx.lum   = (e.ch == CH_UI) ? LUM_III : LUM_II;
				r.ctx.state = ST_END;
			end
			ST_LUM_V: begin
				r.ctx.lum   = (e.ch == CH_UI) ? LUM_VI : LUM_V;
				r.ctx.state = ST_END;
			end
			default: begin
				r.ctx.state = ST_END;
			end
		endcase
		return r;
	endfunction

	// closing effect of the implicit terminator, fed until the end state
	function automatic ctx_t parse_close(input ctx_t c);
		ctx_t r;
		r = c;
		case (c.state)
			ST_WD:     r.spectral = SPEC_D;
			ST_LUM_I:  r.lum      = LUM_I;
			ST_LUM_IA: r.lum      = LUM_IA;
			ST_LUM_II: r.lum      = LUM_II;
			ST_LUM_V:  r.lum      = LUM_V;
			default:   r.lum      = c.lum;
		endcase
		r.state = ST_END;
		return r;
	endfunction

endpackage

### design/scsp_front.sv
module scsp_front import scsp_pkg::*; (
	input  logic [7:0] char_code,
	input  logic       last_char,
	output entry_t     entry
);

	// main class letter lookup
	function automatic logic [4:0] main_class(input logic [7:0] c);
		logic [4:0] k;
		case (c)
			CH_UO:   k = SPEC_O;
			CH_UB:   k = SPEC_B;
			CH_UA:   k = SPEC_A;
			CH_UF:   k = SPEC_F;
			CH_UG:   k = SPEC_G;
			CH_UK:   k = SPEC_K;
			CH_UM:   k = SPEC_M;
			CH_UR:   k = SPEC_R;
			CH_UN:   k = SPEC_N;
			CH_UC:   k = SPEC_C;
			CH_US:   k = SPEC_S;
			CH_UL:   k = SPEC_L;
			CH_UT:   k = SPEC_T;
			CH_UY:   k = SPEC_Y;
			default: k = SPEC_UNKNOWN;
		endcase
		return k;
	endfunction

	// white dwarf type letter lookup
	function automatic logic [4:0] wd_class(input logic [7:0] c);
		logic [4:0] k;
		case (c)
			CH_UA:   k = SPEC_DA;
			CH_UB:   k = SPEC_DB;
			CH_UC:   k = SPEC_DC;
			CH_UO:   k = SPEC_DO;
			CH_UQ:   k = SPEC_DQ;
			CH_UX:   k = SPEC_DX;
			CH_UZ:   k = SPEC_DZ;
			default: k = SPEC_UNKNOWN;
		endcase
		return k;
	endfunction

	// classify the character ahead of the parser
	// digit value is the low nibble since '0' sits at 0x30
	always_comb begin
		entry.ch       = char_code;
		entry.last     = last_char;
		entry.main_cls = main_class(char_code);
		entry.wd_cls   = wd_class(char_code);
		entry.is_dig   = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
		entry.dig      = char_code[3:0];
	end

endmodule

### design/scsp_queue.sv
module scsp_queue import scsp_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t din,
	output logic   full,
	input  logic   pop,
	output logic   valid,
	output entry_t dout
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	entry_t          mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;

	assign full  = (cnt_q == CNT_FULL);
	assign valid = (cnt_q != '0);
	assign dout  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### design/scsp_back.sv
module scsp_back import scsp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  entry_t      q_data,
	output logic        q_pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata
);

	ctx_t       ctx_q;
	ctx_t       fed;
	ctx_t       closed;
	logic       out_valid_q;
	logic [1:0] star_q;
	logic [4:0] spec_q;
	logic [6:0] sub_q;
	logic [3:0] lum_q;
	logic       err_q;

	// take an item unless it closes a string and the result slot is blocked
	assign q_pop = q_valid && (!q_data.last || !out_valid_q || m_tready);

	// walk the character through the state machine until it is consumed
	always_comb begin
		adv_t r;
		logic done;
		r    = '0;
		fed  = ctx_q;
		done = 1'b0;
		for (int i = 0; i < MAX_HOPS; i++) begin
			if (!done) begin
				if (fed.state == ST_END) begin
					done = 1'b1;
				end else begin
					r   = parse_advance(fed, q_data);
					fed = r.ctx;
					if (r.used) begin
						fed.prev_char = q_data.ch;
						done          = 1'b1;
					end
				end
			end
		end
		closed = parse_close(fed);
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q <= CTX_RESET;
		end else if (q_pop) begin
			ctx_q <= q_data.last ? CTX_RESET : fed;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop && q_data.last) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_data.last) begin
			star_q <= closed.star_type;
			spec_q <= closed.spectral;
			sub_q  <= closed.subclass;
			lum_q  <= closed.lum;
			err_q  <= closed.err;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, err_q, lum_q, sub_q, spec_q, star_q};

endmodule

### design/stellar_class_string_parser.sv
// with the queue empty, a request carrying tlast is written into the queue and
// then parsed into the result register that drives m_tdata
// throughput: one character per cycle while the queue is not full; the parse
// stage resolves the whole transition chain of a character combinationally
// a small queue between classifier and parser absorbs output stalls
// reset: arst_n clears the queue, the parser state and the result valid flag
module stellar_class_string_parser import scsp_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        s_tlast,   // last_char
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // [1:0] star_type, [6:2] spectral_class,
	                               // [13:7] subclass_tenths, [17:14] luminosity_class,
	                               // [18] format_error, rest zero
);

	entry_t in_entry;
	entry_t q_data;
	logic   q_full;
	logic   q_valid;
	logic   q_pop;
	logic   push;

	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;

	// classify incoming characters
	scsp_front u_front (
		.char_code (s_tdata),
		.last_char (s_tlast),
		.entry     (in_entry)
	);

	// decoupling queue
	scsp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (in_entry),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.dout   (q_data)
	);

	// parse and emit results
	scsp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_data   (q_data),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
